// File: rtl/kms_pkg.sv
`default_nettype none
package kms_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int NUM_ROWS     = 8;
  localparam int KEYS_PER_ROW = 5;
  localparam int NUM_KEYS     = NUM_ROWS * KEYS_PER_ROW;

  localparam int ROW_W     = $clog2(NUM_ROWS);
  localparam int BITS_W    = KEYS_PER_ROW;
  localparam int BIT_IDX_W = $clog2(KEYS_PER_ROW);
  localparam int STEP_W    = $clog2(KEYS_PER_ROW + 1);
  localparam int KEY_IDX_W = $clog2(NUM_KEYS);
  localparam int CD_W      = 8;
  localparam int CODE_W    = 16;
  localparam int PEND_W    = 5;
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W = 1;

  localparam logic [CD_W-1:0] DELAY_RESET  = 8'd25;
  localparam logic [CD_W-1:0] PERIOD_RESET = 8'd1;

  // address high byte of each half-row
  localparam logic [7:0] ROW_HI [NUM_ROWS] = '{
    8'h7F, 8'hBF, 8'hDF, 8'hEF, 8'hF7, 8'hFB, 8'hFD, 8'hFE
  };

  // keys that always read as released
  localparam logic [BITS_W-1:0] ROW_FORCED_UP [NUM_ROWS] = '{
    5'h02, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h01
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPEAT_DELAY  = 1'b0,
    REG_REPEAT_PERIOD = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_SCAN = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic            down;
    logic [CD_W-1:0] cd;
  } key_ent_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              caps;
    logic              sym;
  } event_t;

  typedef struct packed {
    logic                 we;
    logic [KEY_IDX_W-1:0] waddr;
    key_ent_t             wdata;
    logic                 re;
    logic [KEY_IDX_W-1:0] raddr;
  } key_req_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    event_t data;
  } fifo_req_t;

  function automatic logic [KEY_IDX_W-1:0] key_index(input logic [ROW_W-1:0] row,
                                                     input logic [BIT_IDX_W-1:0] b);
    key_index = KEY_IDX_W'(int'(row) * KEYS_PER_ROW + int'(b));
  endfunction

endpackage
`default_nettype wire

// File: rtl/key_matrix_scanner_autorepeat.sv
// a scan steps through SCAN then DONE, a pop through POP then DONE; from DONE the result goes
// into the output register once it is free; the key state memory is read and written back once
// per key, five keys in turn, over one read and one write port; a new transaction is taken only
// in IDLE, and may be taken while the previous result still waits in the output register
// reset (synchronous, rst_n low): no key down, no repeat key, event queue empty,
// repeat delay 25 and period 1; key state valid bits clear at once, no clearing pass
`default_nettype none
module key_matrix_scanner_autorepeat (
  input  wire                              clk,
  input  wire                              rst_n,
  // item channel
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              in_cmd,
  input  wire  [kms_pkg::ROW_W-1:0]        in_row,
  input  wire  [kms_pkg::BITS_W-1:0]       in_row_bits,
  input  wire                              in_caps_level,
  input  wire                              in_symbol_level,
  // result channel
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             out_event_valid,
  output logic [kms_pkg::CODE_W-1:0]       out_key_code,
  output logic                             out_event_caps,
  output logic                             out_event_symbol,
  output logic [kms_pkg::PEND_W-1:0]       out_pending,
  // configuration writes
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [kms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [kms_pkg::CD_W-1:0]         cfg_data
);
  import kms_pkg::*;

  // sequencer state
  state_t                 state_r, state_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic                   pop_hit_r, pop_hit_nxt;

  // captured scan transaction
  logic [ROW_W-1:0]       row_r;
  logic [BITS_W-1:0]      bits_r;
  logic                   caps_r;
  logic                   sym_r;

  // last newly pressed key
  logic [KEY_IDX_W-1:0]   rk_r, rk_nxt;
  logic                   rk_vld_r, rk_vld_nxt;

  // configuration
  logic [CD_W-1:0]        delay_r;
  logic [CD_W-1:0]        period_r;

  // result register
  logic                   out_valid_r;
  logic                   out_event_valid_r;
  logic [CODE_W-1:0]      out_key_code_r;
  logic                   out_event_caps_r;
  logic                   out_event_symbol_r;
  logic [PEND_W-1:0]      out_pending_r;

  key_req_t               key_req;
  key_ent_t               key_rdata;
  fifo_req_t              fifo_req;
  event_t                 fifo_rdata;
  logic [QCNT_W-1:0]      fifo_count;

  logic                   accept;
  logic                   out_load;
  logic [BIT_IDX_W-1:0]   ubit;
  logic [KEY_IDX_W-1:0]   uidx;
  logic                   level;
  logic                   enq;
  logic [QCNT_W+PEND_W-1:0] pend_ext;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;

  // key being written back is the one before the key being read
  assign ubit  = BIT_IDX_W'(step_r - 1'b1);
  assign uidx  = key_index(row_r, ubit);
  assign level = bits_r[ubit] | ROW_FORCED_UP[row_r][ubit];

  kms_key_ram u_key_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_i   (key_req),
    .rdata_o (key_rdata)
  );

  kms_event_fifo u_event_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_i   (fifo_req),
    .rdata_o (fifo_rdata),
    .count_o (fifo_count)
  );

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    pop_hit_nxt    = pop_hit_r;
    rk_nxt         = rk_r;
    rk_vld_nxt     = rk_vld_r;
    enq            = 1'b0;
    key_req        = '0;
    fifo_req       = '0;
    fifo_req.data.code = {ROW_HI[row_r], (CODE_W-8-BITS_W)'(0),
                          BITS_W'(1) << ubit};
    fifo_req.data.caps = caps_r;
    fifo_req.data.sym  = sym_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          step_nxt    = '0;
          pop_hit_nxt = 1'b0;
          state_nxt   = (cmd_t'(in_cmd) == CMD_POP) ? ST_POP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // read key at step, update key at step - 1
        key_req.re    = (step_r < STEP_W'(KEYS_PER_ROW));
        key_req.raddr = key_index(row_r, step_r[BIT_IDX_W-1:0]);
        if (step_r != '0) begin
          key_req.we    = 1'b1;
          key_req.waddr = uidx;
          if (level) begin
            // released
            key_req.wdata = '0;
          end else if (key_rdata.down) begin
            key_req.wdata = key_rdata;
            if (rk_vld_r && (rk_r == uidx)) begin
              if (key_rdata.cd != '0) begin
                key_req.wdata.cd = key_rdata.cd - 1'b1;
              end else begin
                key_req.wdata.cd = period_r;
                enq              = 1'b1;
              end
            end
          end else begin
            // new press
            key_req.wdata.down = 1'b1;
            key_req.wdata.cd   = delay_r;
            rk_nxt             = uidx;
            rk_vld_nxt         = 1'b1;
            enq                = 1'b1;
          end
        end
        fifo_req.push = enq;
        if (step_r == STEP_W'(KEYS_PER_ROW)) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_POP: begin
        fifo_req.pop = (fifo_count != '0);
        pop_hit_nxt  = (fifo_count != '0);
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      step_r    <= '0;
      pop_hit_r <= 1'b0;
      rk_r      <= '0;
      rk_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      pop_hit_r <= pop_hit_nxt;
      rk_r      <= rk_nxt;
      rk_vld_r  <= rk_vld_nxt;
    end
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (accept) begin
      row_r  <= in_row;
      bits_r <= in_row_bits;
      caps_r <= in_caps_level;
      sym_r  <= in_symbol_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= DELAY_RESET;
      period_r <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REPEAT_DELAY:  delay_r  <= cfg_data;
        REG_REPEAT_PERIOD: period_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // pending is the queue count masked to the field width
  assign pend_ext = {PEND_W'(0), fifo_count};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_event_valid_r  <= pop_hit_r;
      out_key_code_r     <= pop_hit_r ? fifo_rdata.code : '0;
      out_event_caps_r   <= pop_hit_r && fifo_rdata.caps;
      out_event_symbol_r <= pop_hit_r && fifo_rdata.sym;
      out_pending_r      <= pend_ext[PEND_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_valid  = out_event_valid_r;
  assign out_key_code     = out_key_code_r;
  assign out_event_caps   = out_event_caps_r;
  assign out_event_symbol = out_event_symbol_r;
  assign out_pending      = out_pending_r;

  // key write-back only happens behind a read, inside a scan
  a_key_we_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    key_req.we |-> (state_r == ST_SCAN) && (step_r != '0))
    else $error("key write outside scan update");

  // pops are only issued against a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_req.pop |-> (fifo_count != '0))
    else $error("pop issued on empty queue");

  // an accepted transaction leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE))
    else $error("sequencer did not start after acceptance");

  // a push grows the queue by one unless it was full
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (fifo_req.push && (fifo_count != QCNT_W'(QUEUE_DEPTH)))
      |=> (fifo_count == $past(fifo_count) + 1'b1))
    else $error("queue count did not follow push");

endmodule
`default_nettype wire

// File: rtl/kms_key_ram.sv
`default_nettype none
module kms_key_ram (
  input  wire                clk,
  input  wire                rst_n,
  input  kms_pkg::key_req_t  req_i,
  output kms_pkg::key_ent_t  rdata_o
);
  import kms_pkg::*;

  key_ent_t              mem [NUM_KEYS];
  logic [NUM_KEYS-1:0]   vld_r;
  key_ent_t              rdata_r;
  logic                  rvld_r;

  always_ff @(posedge clk) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_r <= mem[req_i.raddr];
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_r[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvld_r <= vld_r[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvld_r ? rdata_r : '0;

endmodule
`default_nettype wire

// File: rtl/kms_event_fifo.sv
`default_nettype none
module kms_event_fifo (
  input  wire                          clk,
  input  wire                          rst_n,
  input  kms_pkg::fifo_req_t           req_i,
  output kms_pkg::event_t              rdata_o,
  output logic [kms_pkg::QCNT_W-1:0]   count_o
);
  import kms_pkg::*;

  event_t              mem [QUEUE_DEPTH];
  event_t              rdata_r;
  logic [QPTR_W-1:0]   head_r;
  logic [QPTR_W-1:0]   head_nxt;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;
  logic [QPTR_W:0]     tail_sum;
  logic [QPTR_W:0]     tail_wrap;
  logic [QPTR_W-1:0]   tail;
  logic                full;
  logic                do_push;
  logic                do_pop;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign do_push  = req_i.push && !full;
  assign do_pop   = req_i.pop && (count_r != '0);

  // head + count stays below twice the depth
  assign tail_sum  = {1'b0, head_r} + (QPTR_W+1)'(count_r);
  assign tail_wrap = (tail_sum >= (QPTR_W+1)'(QUEUE_DEPTH))
                     ? tail_sum - (QPTR_W+1)'(QUEUE_DEPTH) : tail_sum;
  assign tail      = tail_wrap[QPTR_W-1:0];

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop) begin
      count_nxt = count_r - 1'b1;
      head_nxt  = (head_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= req_i.data;
    end
    if (do_pop) begin
      rdata_r <= mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  assign rdata_o = rdata_r;
  assign count_o = count_r;

endmodule
`default_nettype wire
